// ----- rtl/display_frame_deframer_decoder_macros.svh -----
// Assertion macros shared by the display frame decoder.
`ifndef DISPLAY_FRAME_DEFRAMER_DECODER_MACROS_SVH
`define DISPLAY_FRAME_DEFRAMER_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define DFD_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DFD_ASSERT_IMPLIES(name, ante, cons)

`define DFD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- rtl/dfd_pkg.sv -----
package dfd_pkg;

    localparam int DATA_BYTES = 28;
    localparam int POS_W      = 5;
    localparam int UNIT_W     = 20;
    localparam int ACC_W      = 24;
    localparam int LIMIT_W    = 40;
    localparam int PROD_W     = UNIT_W + ACC_W;
    localparam int SCALED_W   = 34;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BYTES - 1);

    localparam logic [7:0] SYNC_S     = 8'h73;
    localparam logic [7:0] SYNC_T     = 8'h74;
    localparam logic [7:0] SYNC_X     = 8'h78;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam int         BUTTON_BIT  = 3;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;
    localparam logic [3:0] NIB_LITERS  = 4'd10;
    localparam logic [3:0] NIB_PRICE   = 4'd12;
    localparam logic [3:0] DIGIT_ONE   = 4'd1;

    localparam logic [9:0] TOTAL_SCALE = 10'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000);

    typedef struct packed {
        logic [UNIT_W-1:0] price_each;
        logic [ACC_W-1:0]  sale_total;
        logic [ACC_W-1:0]  volume;
        logic              pump_running;
        logic              select_liters;
        logic              select_price;
        logic [7:0]        input_signal;
        logic [15:0]       link_version;
        logic              button_pressed;
        logic              dispense_finished;
    } dfd_frame_t;

    function automatic logic [3:0] digit_of(input logic [7:0] rx_byte);
        logic [3:0] nib;
        nib = rx_byte[7:4];
        return (nib >= DIGIT_LIMIT) ? 4'd0 : nib;
    endfunction

    function automatic logic [ACC_W-1:0] times_ten_add(input logic [ACC_W-1:0] acc,
                                                       input logic [3:0] dig);
        return (acc << 3) + (acc << 1) + ACC_W'(dig);
    endfunction

endpackage

// ----- rtl/dfd_ifs.sv -----
interface dfd_cfg_if;
    import dfd_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfd_res_if;
    import dfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] price_each;
    logic [ACC_W-1:0]  sale_total;
    logic [ACC_W-1:0]  volume;
    logic              pump_running;
    logic              select_liters;
    logic              select_price;
    logic [7:0]        input_signal;
    logic [15:0]       link_version;
    logic              button_pressed;
    logic              dispense_finished;
    logic              total_mismatch;
    modport source (output valid, output price_each, output sale_total, output volume,
                    output pump_running, output select_liters, output select_price,
                    output input_signal, output link_version, output button_pressed,
                    output dispense_finished, output total_mismatch, input ready);
    modport sink (input valid, input price_each, input sale_total, input volume,
                  input pump_running, input select_liters, input select_price,
                  input input_signal, input link_version, input button_pressed,
                  input dispense_finished, input total_mismatch, output ready);
endinterface

// ----- rtl/dfd_parser.sv -----
`include "display_frame_deframer_decoder_macros.svh"

module dfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    dfd_rx_if.sink              rx,
    output dfd_pkg::dfd_frame_t frm,
    output logic                frm_valid,
    input  logic                frm_ready
);
    import dfd_pkg::*;

    localparam logic [2:0] PH_S    = 3'd0;
    localparam logic [2:0] PH_T    = 3'd1;
    localparam logic [2:0] PH_X    = 3'd2;
    localparam logic [2:0] PH_VER  = 3'd3;
    localparam logic [2:0] PH_SIG  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;

    localparam logic [POS_W-1:0] POS_SEL_PRICE   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SEL_LITERS  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_VOL_FIRST   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_VOL_LAST    = POS_W'(14);
    localparam logic [POS_W-1:0] POS_TOTAL_FIRST = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TOTAL_LAST  = POS_W'(15);
    localparam logic [POS_W-1:0] POS_RUN         = POS_W'(16);
    localparam logic [POS_W-1:0] POS_UNIT_FIRST  = POS_W'(17);

    logic [2:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       version_reg, version_next;
    logic [7:0]        signal_reg, signal_next;
    logic [7:0]        last_signal_reg, last_signal_next;
    logic              last_running_reg, last_running_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic [ACC_W-1:0]  total_reg, total_next;
    logic [ACC_W-1:0]  vol_reg, vol_next;
    logic              running_reg, running_next;
    logic              sel_l_reg, sel_l_next;
    logic              sel_p_reg, sel_p_next;

    logic              accept;
    logic [3:0]        dig;
    logic [3:0]        nib;
    logic [7:0]        ver_digit;

    assign rx.ready  = frm_ready;
    assign accept    = rx.valid && frm_ready;
    assign nib       = rx.rx_byte[7:4];
    assign dig       = digit_of(rx.rx_byte);
    assign ver_digit = rx.rx_byte - ASCII_ZERO;

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        version_next      = version_reg;
        signal_next       = signal_reg;
        last_signal_next  = last_signal_reg;
        last_running_next = last_running_reg;
        unit_next         = unit_reg;
        total_next        = total_reg;
        vol_next          = vol_reg;
        running_next      = running_reg;
        sel_l_next        = sel_l_reg;
        sel_p_next        = sel_p_reg;
        frm_valid         = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_T:
                begin
                    phase_next = (rx.rx_byte == SYNC_T) ? PH_X : PH_S;
                end
                PH_X:
                begin
                    if (rx.rx_byte == SYNC_X)
                    begin
                        phase_next = PH_VER;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_S;
                    end
                end
                PH_VER:
                begin
                    if (pos_reg == '0)
                    begin
                        version_next = {8'h00, ver_digit};
                        pos_next     = POS_W'(1);
                    end
                    else
                    begin
                        version_next = {version_reg[7:0], ver_digit};
                        phase_next   = PH_SIG;
                    end
                end
                PH_SIG:
                begin
                    signal_next = rx.rx_byte;
                    phase_next  = PH_DATA;
                    pos_next    = '0;
                    unit_next   = '0;
                    total_next  = '0;
                    vol_next    = '0;
                end
                PH_DATA:
                begin
                    if (pos_reg == POS_SEL_PRICE)
                    begin
                        sel_p_next = (nib == NIB_PRICE);
                    end
                    if (pos_reg == POS_SEL_LITERS)
                    begin
                        sel_l_next = (nib == NIB_LITERS);
                    end
                    if (pos_reg == POS_RUN)
                    begin
                        running_next = (dig == DIGIT_ONE);
                    end
                    if (!pos_reg[0] && pos_reg >= POS_VOL_FIRST && pos_reg <= POS_VOL_LAST)
                    begin
                        vol_next = times_ten_add(vol_reg, dig);
                    end
                    if (pos_reg[0] && pos_reg >= POS_TOTAL_FIRST
                        && pos_reg <= POS_TOTAL_LAST)
                    begin
                        total_next = times_ten_add(total_reg, dig);
                    end
                    if (pos_reg[0] && pos_reg >= POS_UNIT_FIRST)
                    begin
                        unit_next = UNIT_W'(times_ten_add(ACC_W'(unit_reg), dig));
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        phase_next        = PH_S;
                        pos_next          = '0;
                        frm_valid         = 1'b1;
                        last_signal_next  = signal_reg;
                        last_running_next = running_reg;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = (rx.rx_byte == SYNC_S) ? PH_T : PH_S;
                end
            endcase
        end
    end

    always_comb
    begin
        frm.price_each        = UNIT_W'(times_ten_add(ACC_W'(unit_reg), dig));
        frm.sale_total        = total_reg;
        frm.volume            = vol_reg;
        frm.pump_running      = running_reg;
        frm.select_liters     = sel_l_reg;
        frm.select_price      = sel_p_reg;
        frm.input_signal      = signal_reg;
        frm.link_version      = version_reg;
        frm.button_pressed    = (signal_reg != last_signal_reg) && signal_reg[BUTTON_BIT];
        frm.dispense_finished = !running_reg && last_running_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_S;
            pos_reg          <= '0;
            version_reg      <= '0;
            signal_reg       <= '0;
            last_signal_reg  <= '0;
            last_running_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            version_reg      <= version_next;
            signal_reg       <= signal_next;
            last_signal_reg  <= last_signal_next;
            last_running_reg <= last_running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg    <= unit_next;
        total_reg   <= total_next;
        vol_reg     <= vol_next;
        running_reg <= running_next;
        sel_l_reg   <= sel_l_next;
        sel_p_reg   <= sel_p_next;
    end

    `DFD_ASSERT_NEXT(a_hunt_after_frame, frm_valid, phase_reg == PH_S && pos_reg == '0)
    `DFD_ASSERT_IMPLIES(a_pos_in_range, phase_reg == PH_DATA, pos_reg <= LAST_POS)
    `DFD_ASSERT_IMPLIES(a_frame_at_last_byte, frm_valid, phase_reg == PH_DATA && pos_reg == LAST_POS)

endmodule

// ----- rtl/dfd_check.sv -----
`include "display_frame_deframer_decoder_macros.svh"

module dfd_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfd_pkg::dfd_frame_t          frm,
    input  logic                         frm_valid,
    output logic                         frm_ready,
    input  logic [dfd_pkg::LIMIT_W-1:0]  limit,
    dfd_res_if.source                    res
);
    import dfd_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic               s3_valid_reg, s3_valid_next;
    logic               out_valid_reg, out_valid_next;
    dfd_frame_t         s1_reg;
    dfd_frame_t         s2_reg;
    dfd_frame_t         s3_reg;
    dfd_frame_t         out_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [PROD_W-1:0]  gap_reg;
    logic               mismatch_reg;

    logic               s2_ok;
    logic               s3_ok;
    logic               out_ok;
    logic [PROD_W-1:0]  product;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]  scaled_wide;
    logic [PROD_W-1:0]  gap;

    assign out_ok    = !out_valid_reg || res.ready;
    assign s3_ok     = !s3_valid_reg || out_ok;
    assign s2_ok     = !s2_valid_reg || s3_ok;
    assign frm_ready = !s1_valid_reg || s2_ok;

    assign product     = s1_reg.price_each * s1_reg.volume;
    assign scaled      = s1_reg.sale_total * TOTAL_SCALE;
    assign scaled_wide = PROD_W'(scaled_reg);
    assign gap         = (prod_reg >= scaled_wide) ? prod_reg - scaled_wide
                                                   : scaled_wide - prod_reg;

    always_comb
    begin
        s1_valid_next  = frm_ready ? frm_valid : s1_valid_reg;
        s2_valid_next  = s2_ok ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = s3_ok ? s2_valid_reg : s3_valid_reg;
        out_valid_next = out_ok ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_ready && frm_valid)
        begin
            s1_reg <= frm;
        end
        if (s2_ok && s1_valid_reg)
        begin
            s2_reg     <= s1_reg;
            prod_reg   <= product;
            scaled_reg <= scaled;
        end
        if (s3_ok && s2_valid_reg)
        begin
            s3_reg  <= s2_reg;
            gap_reg <= gap;
        end
        if (out_ok && s3_valid_reg)
        begin
            out_reg      <= s3_reg;
            mismatch_reg <= (gap_reg > PROD_W'(limit));
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.price_each        = out_reg.price_each;
    assign res.sale_total        = out_reg.sale_total;
    assign res.volume            = out_reg.volume;
    assign res.pump_running      = out_reg.pump_running;
    assign res.select_liters     = out_reg.select_liters;
    assign res.select_price      = out_reg.select_price;
    assign res.input_signal      = out_reg.input_signal;
    assign res.link_version      = out_reg.link_version;
    assign res.button_pressed    = out_reg.button_pressed;
    assign res.dispense_finished = out_reg.dispense_finished;
    assign res.total_mismatch    = mismatch_reg;

    `DFD_ASSERT_IMPLIES(a_frame_taken, frm_valid, frm_ready)
    `DFD_ASSERT_NEXT(a_gap_reaches_output, s3_valid_reg && out_ok, out_valid_reg)
    `DFD_ASSERT_NEXT(a_product_moves, s1_valid_reg && s2_ok, s2_valid_reg)

endmodule

// ----- rtl/display_frame_deframer_decoder.sv -----
// Channel | Role   | Beat payload
// cfg     | sink   | data: mismatch limit, 40 bits
// rx      | sink   | rx_byte: one received link byte
// res     | source | decoded frame fields and total_mismatch flag
//
// One byte per cycle unless stalled; a 34-byte frame, sync included, gives one result.
// The result of a frame passes through the frame register and then the multiply,
// gap and compare stages that follow it before res is valid.
// Reset clears the parser phase, the frame history and all stage valids.
// The input stalls only while all four result stages are full and res is held.
module display_frame_deframer_decoder (
    input  logic      clk,
    input  logic      rst_n,
    dfd_cfg_if.sink   cfg,
    dfd_rx_if.sink    rx,
    dfd_res_if.source res
);
    import dfd_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    dfd_frame_t         frm;
    logic               frm_valid;
    logic               frm_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.data;
        end
    end

    dfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .frm       (frm),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready)
    );

    dfd_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .frm       (frm),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .limit     (limit_reg),
        .res       (res)
    );

endmodule

// ----- dv/display_frame_checker.sv -----
`timescale 1ns / 100ps

module display_frame_checker (
    input  logic clk,
    input  logic rst_n,
    dfd_cfg_if   cfg,
    dfd_rx_if    rx,
    dfd_res_if   res,
    output int   fail_count,
    output int   frames_pending
);
    import dfd_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        HUNT_S,
        HUNT_T,
        HUNT_X,
        TAKE_VERSION,
        TAKE_SIGNAL,
        TAKE_DATA
    } parse_phase_t;

    typedef struct packed {
        dfd_frame_t frame;
        logic       total_mismatch;
    } decoded_t;

    parse_phase_t       phase;
    logic [POS_W-1:0]   position;
    logic [15:0]        version_word;
    logic [7:0]         signal_byte;
    logic [7:0]         frame_bytes [DATA_BYTES];
    logic [7:0]         prior_signal;
    logic               prior_running;
    logic [LIMIT_W-1:0] gap_limit;
    decoded_t           frames_due [$];

    function automatic logic [3:0] bcd_digit(input logic [7:0] b);
        return (b[7:4] >= DIGIT_LIMIT) ? 4'd0 : b[7:4];
    endfunction

    function automatic longint unsigned bcd_number(input int first, input int count);
        longint unsigned acc;
        acc = 0;
        for (int k = 0; k < count; k++)
            acc = acc * 10 + bcd_digit(frame_bytes[first + 2 * k]);
        return acc;
    endfunction

    function automatic decoded_t close_frame();
        decoded_t        d;
        longint unsigned unit_val;
        longint unsigned total_val;
        longint unsigned vol_val;
        longint unsigned product;
        longint unsigned scaled;
        longint unsigned gap;
        logic            running;
        unit_val  = bcd_number(17, 6);
        total_val = bcd_number(3, 7);
        vol_val   = bcd_number(2, 7);
        running   = (bcd_digit(frame_bytes[16]) == DIGIT_ONE);
        d.frame.price_each        = unit_val[UNIT_W-1:0];
        d.frame.sale_total        = total_val[ACC_W-1:0];
        d.frame.volume            = vol_val[ACC_W-1:0];
        d.frame.pump_running      = running;
        d.frame.select_liters     = (frame_bytes[1][7:4] == NIB_LITERS);
        d.frame.select_price      = (frame_bytes[0][7:4] == NIB_PRICE);
        d.frame.input_signal      = signal_byte;
        d.frame.link_version      = version_word;
        d.frame.button_pressed    = (signal_byte != prior_signal) && signal_byte[BUTTON_BIT];
        d.frame.dispense_finished = !running && prior_running;
        prior_signal  = signal_byte;
        prior_running = running;
        product = unit_val * vol_val;
        scaled  = total_val * TOTAL_SCALE;
        gap     = (product >= scaled) ? product - scaled : scaled - product;
        d.total_mismatch = (gap > gap_limit);
        return d;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [7:0] dig;
        dig = b - ASCII_ZERO;
        case (phase)
            HUNT_T:
                phase = (b == SYNC_T) ? HUNT_X : HUNT_S;
            HUNT_X:
            begin
                if (b == SYNC_X)
                begin
                    phase    = TAKE_VERSION;
                    position = '0;
                end
                else
                    phase = HUNT_S;
            end
            TAKE_VERSION:
            begin
                if (position == '0)
                begin
                    version_word = {8'd0, dig};
                    position     = POS_W'(1);
                end
                else
                begin
                    version_word = {version_word[7:0], dig};
                    phase        = TAKE_SIGNAL;
                end
            end
            TAKE_SIGNAL:
            begin
                signal_byte = b;
                phase       = TAKE_DATA;
                position    = '0;
            end
            TAKE_DATA:
            begin
                frame_bytes[position] = b;
                if (position >= LAST_POS)
                begin
                    frames_due.push_back(close_frame());
                    phase    = HUNT_S;
                    position = '0;
                end
                else
                    position = position + 1'b1;
            end
            default:
                phase = (b == SYNC_S) ? HUNT_T : HUNT_S;
        endcase
    endfunction

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic void check_result();
        decoded_t want;
        if (frames_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result beat with no frame outstanding", $time);
            return;
        end
        want = frames_due.pop_front();
        compare_field("price_each", 64'(want.frame.price_each), 64'(res.price_each));
        compare_field("sale_total", 64'(want.frame.sale_total), 64'(res.sale_total));
        compare_field("volume", 64'(want.frame.volume), 64'(res.volume));
        compare_field("pump_running", 64'(want.frame.pump_running), 64'(res.pump_running));
        compare_field("select_liters", 64'(want.frame.select_liters), 64'(res.select_liters));
        compare_field("select_price", 64'(want.frame.select_price), 64'(res.select_price));
        compare_field("input_signal", 64'(want.frame.input_signal), 64'(res.input_signal));
        compare_field("link_version", 64'(want.frame.link_version),
                      64'(res.link_version));
        compare_field("button_pressed", 64'(want.frame.button_pressed),
                      64'(res.button_pressed));
        compare_field("dispense_finished", 64'(want.frame.dispense_finished),
                      64'(res.dispense_finished));
        compare_field("total_mismatch", 64'(want.total_mismatch), 64'(res.total_mismatch));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase         = HUNT_S;
            position      = '0;
            version_word  = '0;
            signal_byte   = '0;
            prior_signal  = '0;
            prior_running = 1'b0;
            gap_limit     = LIMIT_RESET;
            for (int i = 0; i < DATA_BYTES; i++)
                frame_bytes[i] = '0;
            frames_due.delete();
            frames_pending = 0;
            fail_count     = 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (cfg.valid && cfg.ready)
                gap_limit = cfg.data;
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte);
            frames_pending = frames_due.size();
        end
    end

endmodule

// ----- dv/display_frame_deframer_decoder_tb.sv -----
`timescale 1ns / 100ps

module display_frame_deframer_decoder_tb;
    import dfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 220;
    localparam int HOLD_CYCLES    = 600;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_mode_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    int         fail_count;
    int         frames_pending;
    int         rx_idle_pct     = 0;
    int         res_stall_pct   = 0;
    int         res_hold_cycles = 0;
    int         quiet_cycles    = 0;
    int         bytes_sent      = 0;
    logic [7:0] frame_body [DATA_BYTES];

    dfd_cfg_if cfg_ch ();
    dfd_rx_if  rx_ch ();
    dfd_res_if res_ch ();

    display_frame_deframer_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    display_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .rx             (rx_ch),
        .res            (res_ch),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (res_hold_cycles > 0)
        begin
            res_ch.ready <= 1'b0;
            res_hold_cycles = res_hold_cycles - 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_SENDER_IDLE:
            begin
                rx_idle_pct   = 72;
                res_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL:
            begin
                rx_idle_pct   = 0;
                res_stall_pct = 72;
            end
            FLOW_BOTH:
            begin
                rx_idle_pct   = 15;
                res_stall_pct = 15;
            end
            default:
            begin
                rx_idle_pct   = 0;
                res_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic void fill_body(input logic [7:0] b);
        for (int i = 0; i < DATA_BYTES; i++)
            frame_body[i] = b;
    endfunction

    function automatic void put_number(input int first, input int count,
                                       input longint unsigned value);
        longint unsigned v;
        v = value;
        for (int k = count - 1; k >= 0; k--)
        begin
            frame_body[first + 2 * k] = {4'(v % 10), 4'($urandom_range(15))};
            v = v / 10;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < rx_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        rx_ch.valid <= 1'b0;
        wait (frames_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= limit;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] ver_hi, input logic [7:0] ver_lo,
                              input logic [7:0] sig);
        send_byte(SYNC_S);
        send_byte(SYNC_T);
        send_byte(SYNC_X);
        send_byte(ver_hi);
        send_byte(ver_lo);
        send_byte(sig);
        for (int i = 0; i < DATA_BYTES; i++)
            send_byte(frame_body[i]);
    endtask

    task automatic random_frame();
        longint unsigned unit_val;
        longint unsigned vol_val;
        longint unsigned total_val;
        logic [7:0]      ver_hi;
        logic [7:0]      ver_lo;
        logic [7:0]      sig;
        for (int i = 0; i < DATA_BYTES; i++)
            frame_body[i] = 8'($urandom);
        if ($urandom_range(3) != 0)
        begin
            // Keep the total near unit price times volume so the gap check sees both sides.
            unit_val  = $urandom_range(99999);
            vol_val   = $urandom_range(99999);
            total_val = unit_val * vol_val / 1000 + $urandom_range(2);
            if (total_val > 9999999)
                total_val = 9999999;
            put_number(17, 6, unit_val);
            put_number(3, 7, total_val);
            put_number(2, 7, vol_val);
        end
        else if ($urandom_range(1) != 0)
        begin
            put_number(17, 6, $urandom_range(999999));
            put_number(3, 7, $urandom_range(9999999));
            put_number(2, 7, $urandom_range(9999999));
        end
        if ($urandom_range(1) != 0)
            frame_body[0][7:4] = NIB_PRICE;
        if ($urandom_range(1) != 0)
            frame_body[1][7:4] = NIB_LITERS;
        if ($urandom_range(2) != 0)
            frame_body[16][7:4] = 4'($urandom_range(1));
        case ($urandom_range(3))
            0: sig = 8'h00;
            1: sig = 8'h08;
            2: sig = 8'h18;
            default: sig = 8'($urandom);
        endcase
        if ($urandom_range(3) == 0)
        begin
            ver_hi = 8'($urandom);
            ver_lo = 8'($urandom);
        end
        else
        begin
            ver_hi = ASCII_ZERO + 8'($urandom_range(9));
            ver_lo = ASCII_ZERO + 8'($urandom_range(9));
        end
        send_frame(ver_hi, ver_lo, sig);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom));
    endtask

    task automatic send_broken();
        case ($urandom_range(2))
            0:
            begin
                send_byte(SYNC_S);
                send_byte(SYNC_T);
                send_byte(8'($urandom));
            end
            1:
            begin
                send_byte(SYNC_S);
                send_byte(8'($urandom));
            end
            default:
            begin
                send_byte(SYNC_S);
                send_byte(SYNC_T);
                send_byte(SYNC_X);
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic run_phase(input flow_mode_t mode, input logic [LIMIT_W-1:0] limit);
        int start;
        write_limit(limit);
        set_flow(mode);
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            case ($urandom_range(9))
                0: send_noise();
                1: send_broken();
                default: random_frame();
            endcase
        end
    endtask

    initial
    begin
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A byte that breaks a sync is not taken as a new start.
        send_byte(SYNC_S);
        send_byte(SYNC_S);
        send_byte(SYNC_T);
        send_byte(SYNC_X);
        fill_body(8'hFF);
        send_frame(8'h00, 8'hFF, 8'hFF);

        send_byte(SYNC_S);
        send_byte(SYNC_T);
        send_byte(SYNC_S);
        send_byte(SYNC_T);
        send_byte(SYNC_X);
        fill_body(8'h9A);
        send_frame(ASCII_ZERO, ASCII_ZERO + 8'd9, 8'h08);

        fill_body(8'h05);
        frame_body[0]  = {NIB_PRICE, 4'h3};
        frame_body[1]  = {NIB_LITERS, 4'hC};
        frame_body[16] = {DIGIT_ONE, 4'h0};
        put_number(17, 6, 100);
        put_number(2, 7, 1000);
        put_number(3, 7, 100);
        send_frame(8'h31, 8'h32, 8'h08);

        frame_body[16] = 8'h00;
        put_number(17, 6, 999999);
        put_number(2, 7, 0);
        put_number(3, 7, 9999999);
        send_frame(8'hFF, 8'h00, 8'h00);

        for (int i = 0; i < DATA_BYTES; i++)
            frame_body[i] = {4'(10 + i % 6), 4'(i)};
        send_frame(8'h39, 8'h30, 8'hF7);

        run_phase(FLOW_FREE, '0);
        run_phase(FLOW_SENDER_IDLE, '1);
        run_phase(FLOW_RECEIVER_STALL, LIMIT_W'(1000));
        run_phase(FLOW_BOTH, {8'($urandom), 32'($urandom)});

        // The result side holds off while beats keep coming, so the input must stall.
        write_limit(LIMIT_RESET);
        set_flow(FLOW_FREE);
        res_hold_cycles = HOLD_CYCLES;
        repeat (10) random_frame();

        run_phase(FLOW_FREE, LIMIT_W'($urandom_range(5000)));

        rx_ch.valid <= 1'b0;
        set_flow(FLOW_FREE);
        wait (frames_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && frames_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- display_frame_deframer_decoder.f -----
+incdir+rtl
rtl/dfd_pkg.sv
rtl/dfd_ifs.sv
rtl/dfd_parser.sv
rtl/dfd_check.sv
rtl/display_frame_deframer_decoder.sv
dv/display_frame_checker.sv
dv/display_frame_deframer_decoder_tb.sv
